@@ hw/rtl/btop_pkg.sv @@
// ----------------------------------------------------------------------------
// btop_pkg
// shared constants, types and the q2.30 product rounding helper
// ----------------------------------------------------------------------------
package btop_pkg;

   localparam int DefaultMaxSteps = 1024;

   localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [31:0] HALF_Q30 = 32'h2000_0000;
   localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

   localparam logic [2:0] REG_UP   = 3'd0;
   localparam logic [2:0] REG_DOWN = 3'd1;
   localparam logic [2:0] REG_PROB = 3'd2;
   localparam logic [2:0] REG_DISC = 3'd3;
   localparam logic [2:0] REG_STEPS = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOWN,
      ST_LEAF,
      ST_MIX,
      ST_DISC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] up_factor;
      logic [31:0] down_factor;
      logic [30:0] up_probability;
      logic [30:0] step_discount;
      logic [10:0] tree_steps;
   } cfg_type;

   typedef struct packed {
      logic [31:0] value;
      logic        sat;
   } rnd_type;

   // round half up, shift by 30, saturate to 32 bits
   function automatic rnd_type round_q30(input logic [63:0] prod);
      logic [64:0] s;
      rnd_type     r;
      s = {1'b0, prod} + 65'(HALF_Q30);
      if (s[64:62] != 3'd0) begin
         r.value = PRICE_MAX;
         r.sat   = 1'b1;
      end else begin
         r.value = s[61:30];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/btop_csr.sv @@
// ----------------------------------------------------------------------------
// btop_csr
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module btop_csr
   import btop_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   logic [2:0] idx;
   logic       wr;

   assign idx = paddr[4:2];
   assign wr  = psel && penable && pwrite;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_factor      <= ONE_Q30;
         cfg_ff.down_factor    <= ONE_Q30;
         cfg_ff.up_probability <= HALF_Q30[30:0];
         cfg_ff.step_discount  <= ONE_Q30[30:0];
         cfg_ff.tree_steps     <= 11'd500;
      end else if (wr) begin
         case (idx)
            REG_UP:    cfg_ff.up_factor      <= pwdata;
            REG_DOWN:  cfg_ff.down_factor    <= pwdata;
            REG_PROB:  cfg_ff.up_probability <= pwdata[30:0];
            REG_DISC:  cfg_ff.step_discount  <= pwdata[30:0];
            REG_STEPS: cfg_ff.tree_steps     <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_UP:    prdata = cfg_ff.up_factor;
         REG_DOWN:  prdata = cfg_ff.down_factor;
         REG_PROB:  prdata = {1'b0, cfg_ff.up_probability};
         REG_DISC:  prdata = {1'b0, cfg_ff.step_discount};
         REG_STEPS: prdata = {21'd0, cfg_ff.tree_steps};
         default:   prdata = 32'd0;
      endcase
   end

endmodule

@@ hw/rtl/btop_mem.sv @@
// ----------------------------------------------------------------------------
// btop_mem
// node value memory, one write and one read port, registered read
// ----------------------------------------------------------------------------
module btop_mem #(
   parameter int Depth = 1025,
   parameter int AddrW = 11
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [31:0]      wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [31:0]      rd_data
);

   logic [31:0] mem [Depth];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/binomial_tree_option_pricer.sv @@
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer
// european option pricing by backward induction on a crr binomial tree
// ----------------------------------------------------------------------------
// One word is priced at a time. With N steps (capped at MAX_STEPS) an item
// first multiplies the spot price by the down factor N times, then builds
// the leaves (two up multiplies between leaves, none after the top leaf).
// In the collapse each node update needs two reads through the single read
// port of the node memory, a mix step and a discount step. The root is read
// back in the done state. With zero steps the down powering and the collapse
// are skipped. A finished result is held in an output register; the next
// word may be accepted while it waits.
module binomial_tree_option_pricer
   import btop_pkg::*;
#(
   parameter int MAX_STEPS = DefaultMaxSteps
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_spot_price,
   input  logic [31:0] req_strike_price,
   input  logic        req_kind,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_option_value,
   output logic        rsp_saturated,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AddrW = $clog2(MAX_STEPS + 1);
   localparam int CntW  = AddrW + 1;

   cfg_type cfg;

   btop_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata), .cfg
   );
   assign csr_pready = 1'b1;

   state_type   state_ff, state_in;
   logic [CntW-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [31:0] leaf_ff, leaf_in, strike_ff, strike_in, acc_ff, acc_in;
   logic [31:0] lo_ff, lo_in;
   logic        kind_ff, kind_in, sat_ff, sat_in, half_ff, half_in;
   logic [1:0]  ph_ff, ph_in;
   logic        out_v_ff, out_v_in, out_s_ff, out_s_in;
   logic [31:0] out_d_ff, out_d_in;
   logic [31:0] p_q, q_q;

   logic             mwe;
   logic [AddrW-1:0] mwa, mra;
   logic [31:0]      mwd, mrd;

   btop_mem #(.Depth(MAX_STEPS + 1), .AddrW(AddrW)) u_mem (
      .clock, .wr_en(mwe), .wr_addr(mwa), .wr_data(mwd),
      .rd_addr(mra), .rd_data(mrd)
   );

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   rnd_type     rnd;
   logic [31:0] pay;
   logic [CntW-1:0] n_cap;

   assign prod = 64'(mul_a) * 64'(mul_b);
   assign rnd  = round_q30(prod);
   assign p_q  = ({1'b0, cfg.up_probability} > ONE_Q30) ? ONE_Q30
                                                      : {1'b0, cfg.up_probability};
   assign q_q  = ONE_Q30 - p_q;
   assign n_cap = ({1'b0, cfg.tree_steps} > CntW'(MAX_STEPS)) ? CntW'(MAX_STEPS)
                  : CntW'(cfg.tree_steps);

   always_comb begin
      if (kind_ff) pay = (strike_ff > leaf_ff) ? strike_ff - leaf_ff : 32'd0;
      else         pay = (leaf_ff > strike_ff) ? leaf_ff - strike_ff : 32'd0;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = out_v_ff;
   assign rsp_option_value = out_d_ff;
   assign rsp_saturated    = out_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      n_ff <= n_in; i_ff <= i_in; j_ff <= j_in;
      leaf_ff <= leaf_in; strike_ff <= strike_in; acc_ff <= acc_in;
      lo_ff <= lo_in; kind_ff <= kind_in; sat_ff <= sat_in;
      half_ff <= half_in; ph_ff <= ph_in;
      out_d_ff <= out_d_in; out_s_ff <= out_s_in;
   end

   // collapse: ph 0 read j, ph 1 read j+1 (lo arrives), ph 2 mix, then disc
   always_comb begin
      state_in = state_ff;
      n_in = n_ff; i_in = i_ff; j_in = j_ff;
      leaf_in = leaf_ff; strike_in = strike_ff; acc_in = acc_ff;
      lo_in = lo_ff; kind_in = kind_ff; sat_in = sat_ff;
      half_in = half_ff; ph_in = ph_ff;
      out_v_in = out_v_ff; out_d_in = out_d_ff; out_s_in = out_s_ff;
      mul_a = leaf_ff; mul_b = cfg.down_factor;
      mwe = 1'b0; mwa = j_ff[AddrW-1:0]; mwd = pay;
      mra = j_ff[AddrW-1:0];
      if (out_v_ff && rsp_ready) out_v_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               leaf_in = req_spot_price; strike_in = req_strike_price;
               kind_in = req_kind; sat_in = 1'b0; n_in = n_cap;
               i_in = '0; j_in = '0; half_in = 1'b0;
               state_in = (n_cap == '0) ? ST_LEAF : ST_DOWN;
            end
         end
         ST_DOWN: begin
            mul_b = cfg.down_factor;
            leaf_in = rnd.value; sat_in = sat_ff | rnd.sat;
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 == n_ff) state_in = ST_LEAF;
         end
         ST_LEAF: begin
            mul_b = cfg.up_factor;
            if (!half_ff) begin
               mwe = 1'b1;
               if (j_ff == n_ff) begin
                  i_in = n_ff; j_in = '0; ph_in = 2'd0;
                  state_in = (n_ff == '0) ? ST_DONE : ST_MIX;
               end else begin
                  leaf_in = rnd.value; sat_in = sat_ff | rnd.sat;
                  half_in = 1'b1;
               end
            end else begin
               leaf_in = rnd.value; sat_in = sat_ff | rnd.sat;
               half_in = 1'b0; j_in = j_ff + 1'b1;
            end
         end
         ST_MIX: begin
            case (ph_ff)
               2'd0: begin
                  mra = j_ff[AddrW-1:0]; ph_in = 2'd1;
               end
               2'd1: begin
                  mra = AddrW'(j_ff + 1'b1); lo_in = mrd; ph_in = 2'd2;
               end
               default: begin
                  mul_a = mrd; mul_b = p_q;
                  acc_in = 32'(({2'b0, prod} + 66'(64'(q_q) * 64'(lo_ff))
                            + 66'(HALF_Q30)) >> 30);
                  state_in = ST_DISC;
               end
            endcase
         end
         ST_DISC: begin
            mul_a = acc_ff; mul_b = {1'b0, cfg.step_discount};
            mwe = 1'b1; mwd = rnd.value; sat_in = sat_ff | rnd.sat;
            ph_in = 2'd0; state_in = ST_MIX;
            if (j_ff + 1'b1 == i_ff) begin
               j_in = '0; i_in = i_ff - 1'b1;
               if (i_ff == CntW'(1)) state_in = ST_DONE;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DONE: begin
            mra = '0;
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else if (!out_v_ff || rsp_ready) begin
               out_v_in = 1'b1; out_d_in = mrd; out_s_in = sat_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
